FILE: hdl/fixed_partition_allocator_assert.svh
// assertion macros used by the checker file
`ifndef FIXED_PARTITION_ALLOCATOR_ASSERT_SVH
`define FIXED_PARTITION_ALLOCATOR_ASSERT_SVH

// clocked property, masked while reset is high
`define FPA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked during reset
`define FPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/fpa_pkg.sv
package fpa_pkg;

  localparam int PARTITION_COUNT_DEF = 4;
  localparam int PARTITION_BYTES_DEF = 256;

  // field widths
  localparam int PID_W      = 16;
  localparam int REQ_SIZE_W = 16;
  localparam int STATUS_W   = 3;
  localparam int INDEX_W    = 2;
  localparam int SIZE_W     = 9;

  // stream widths and field positions
  localparam int S_TDATA_W   = 32;
  localparam int S_TUSER_W   = 1;
  localparam int S_PID_LSB   = 0;
  localparam int S_SIZE_LSB  = 16;
  localparam int M_TDATA_W   = 16;
  localparam int M_TUSER_W   = 3;
  localparam int M_INDEX_LSB = 0;
  localparam int M_SIZE_LSB  = 2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_FREED     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic too_large;
    logic rd_valid;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

FILE: hdl/fixed_partition_allocator.sv
// fixed partition allocator, first fit over equal-sized partitions
// input channel s_*: one request per transfer, s_tuser carries the request kind
//   (0 allocate, 1 free), s_tdata the owner id and the requested byte count
// output channel m_*: exactly one result transfer per request, in request order,
//   m_tuser carries the status, m_tdata the partition index and the freed size
// the controller walks the table one partition per cycle through a
//   registered read port, up to the partition that decides the request; an
//   oversized allocate is decided before any partition is read
// one request is in work at a time: the next is taken only once the result
//   of the last has been moved to the output register
// the output register decouples the sides: a new request is taken while an
//   earlier result still waits, and a further result is held back until the
//   receiver has taken the waiting one
// reset clears the occupied marks, the controller and the output valid; the
//   owner and size stores need no clearing as they are used only for occupied entries
module fixed_partition_allocator import fpa_pkg::*; #(
  parameter int PARTITION_COUNT = PARTITION_COUNT_DEF,
  parameter int PARTITION_BYTES = PARTITION_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] owner_id, [31:16] req_size
  input  logic [S_TUSER_W-1:0] s_tuser,   // [0] req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [1:0] partition_index, [10:2] freed_size, zero pad
  output logic [M_TUSER_W-1:0] m_tuser    // [2:0] status
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  status_t            out_status;
  logic [INDEX_W-1:0] out_index;
  logic [SIZE_W-1:0]  out_size;

  // sequencing of accept, walk, commit and output hand-off
  fpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // partition table, compare and result registers
  fpa_datapath #(
    .PARTITION_COUNT (PARTITION_COUNT),
    .PARTITION_BYTES (PARTITION_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_type    (s_tuser[0]),
    .in_pid     (s_tdata[S_PID_LSB +: PID_W]),
    .in_size    (s_tdata[S_SIZE_LSB +: REQ_SIZE_W]),
    .out_status (out_status),
    .out_index  (out_index),
    .out_size   (out_size)
  );

  // result packing, unused upper bits held at zero
  assign m_tdata = {{(M_TDATA_W - INDEX_W - SIZE_W){1'b0}}, out_size, out_index};
  assign m_tuser = out_status;

endmodule

FILE: hdl/fpa_datapath.sv
module fpa_datapath import fpa_pkg::*; #(
  parameter int PARTITION_COUNT = PARTITION_COUNT_DEF,
  parameter int PARTITION_BYTES = PARTITION_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  in_type,
  input  logic [PID_W-1:0]      in_pid,
  input  logic [REQ_SIZE_W-1:0] in_size,
  output status_t               out_status,
  output logic [INDEX_W-1:0]    out_index,
  output logic [SIZE_W-1:0]     out_size
);

  localparam int IDX_W = (PARTITION_COUNT > 1) ? $clog2(PARTITION_COUNT) : 1;
  localparam int CNT_W = $clog2(PARTITION_COUNT + 1);

  logic [PID_W-1:0]  owner_mem [PARTITION_COUNT];
  logic [SIZE_W-1:0] size_mem  [PARTITION_COUNT];
  logic [PARTITION_COUNT-1:0] occupied;

  logic                  req_type;
  logic [PID_W-1:0]      req_pid;
  logic [REQ_SIZE_W-1:0] req_size;

  logic [CNT_W-1:0]  scan_idx;
  logic              scan_in_range;
  logic              rd_valid;
  logic              rd_occ;
  logic [PID_W-1:0]  rd_owner;
  logic [SIZE_W-1:0] rd_size;
  logic [IDX_W-1:0]  rd_pos;

  logic              too_large;
  logic              hit;
  status_t           res_status;
  logic [INDEX_W-1:0] res_index;
  logic [SIZE_W-1:0]  res_size;
  status_t            pend_status;
  logic [INDEX_W-1:0] pend_index;
  logic [SIZE_W-1:0]  pend_size;

  assign scan_in_range = scan_idx < CNT_W'(PARTITION_COUNT);
  assign too_large     = (req_type == REQ_ALLOC) && (req_size > REQ_SIZE_W'(PARTITION_BYTES));
  assign hit = (req_type == REQ_ALLOC) ? !rd_occ : (rd_occ && (rd_owner == req_pid));

  assign stat.too_large = too_large;
  assign stat.rd_valid  = rd_valid;
  assign stat.hit       = hit;
  assign stat.last      = rd_pos == IDX_W'(PARTITION_COUNT - 1);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_type <= in_type;
      req_pid  <= in_pid;
      req_size <= in_size;
    end
  end

  // walk over the partitions, read data registered
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
    end else if (cmd.start) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
    end else if (cmd.scan) begin
      rd_valid <= scan_in_range;
      if (scan_in_range) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && scan_in_range) begin
      rd_owner <= owner_mem[scan_idx[IDX_W-1:0]];
      rd_size  <= size_mem[scan_idx[IDX_W-1:0]];
      rd_occ   <= occupied[scan_idx[IDX_W-1:0]];
      rd_pos   <= scan_idx[IDX_W-1:0];
    end
  end

  // table update
  always_ff @(posedge clk) begin
    if (cmd.commit && !too_large && hit && (req_type == REQ_ALLOC)) begin
      owner_mem[rd_pos] <= req_pid;
      size_mem[rd_pos]  <= req_size[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
    end else if (cmd.commit && !too_large && hit) begin
      occupied[rd_pos] <= (req_type == REQ_ALLOC);
    end
  end

  // result selection
  always_comb begin
    res_index = '0;
    res_size  = '0;
    if (too_large) begin
      res_status = ST_TOO_LARGE;
    end else if (hit) begin
      res_index = INDEX_W'(rd_pos);
      if (req_type == REQ_ALLOC) begin
        res_status = ST_ALLOCATED;
      end else begin
        res_status = ST_FREED;
        res_size   = rd_size;
      end
    end else begin
      res_status = (req_type == REQ_ALLOC) ? ST_NO_FREE : ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pend_status <= res_status;
      pend_index  <= res_index;
      pend_size   <= res_size;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= pend_status;
      out_index  <= pend_index;
      out_size   <= pend_size;
    end
  end

endmodule

FILE: hdl/fpa_ctrl.sv
module fpa_ctrl import fpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    SCAN = 3'b010,
    EMIT = 3'b100
  } ctl_state_t;

  ctl_state_t state, state_next;
  logic decide;
  logic out_free;

  assign decide   = stat.too_large || (stat.rd_valid && (stat.hit || stat.last));
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == IDLE;

  assign cmd.start    = (state == IDLE) && s_tvalid;
  assign cmd.scan     = state == SCAN;
  assign cmd.commit   = (state == SCAN) && decide;
  assign cmd.load_out = (state == EMIT) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: if (s_tvalid) state_next = SCAN;
      SCAN: if (decide) state_next = EMIT;
      EMIT: if (out_free) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/fpa_checker.sv
`include "fixed_partition_allocator_assert.svh"

module fpa_checker import fpa_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser
);

  // a stalled result keeps its contents
  `FPA_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // status codes stay within the defined set
  `FPA_ASSERT(a_status_range, clk, rst, m_tvalid |-> m_tuser <= M_TUSER_W'(ST_NOT_FOUND), "undefined status code")

  // an error result carries zero index and zero size
  `FPA_ASSERT(a_error_zero, clk, rst, m_tvalid && (m_tuser == M_TUSER_W'(ST_TOO_LARGE) || m_tuser == M_TUSER_W'(ST_NO_FREE) || m_tuser == M_TUSER_W'(ST_NOT_FOUND)) |-> m_tdata == '0, "error result not zeroed")

  // only a release reports a freed size
  `FPA_ASSERT(a_size_free_only, clk, rst, m_tvalid && m_tuser != M_TUSER_W'(ST_FREED) |-> m_tdata[M_SIZE_LSB +: SIZE_W] == '0, "freed size on non-free result")

  // reset leaves no result pending
  `FPA_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind fixed_partition_allocator fpa_checker u_fpa_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
